FILE: hdl/assert_macros.svh
// Assertion macros used by the frame assembler datapath RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Condition must never be true outside reset.
`define RFA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define RFA_ASSERT(lbl, clk, rst_n, prop)
`define RFA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/rfa_pkg.sv
// Shared types and constants of the radio frame assembler.
// No dependencies; used by the top level, rfa_ctrl and rfa_dp.
package rfa_pkg;

    localparam int HOLD_LEN       = 17;
    localparam int ENTER_TEXT_LEN = 15;
    localparam int EXIT_TEXT_LEN  = 16;
    localparam logic [15:0] FRAME_LEN_RESET = 16'd256;

    typedef logic [4:0] t_hold_idx;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BURST
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_word;   // input word accepted this cycle
        logic emit_held;   // move one held byte to the output register
    } t_ctl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_free;   // output register free or draining
        logic want_burst;  // current input word starts a held-byte burst
        logic burst_end;   // burst index sits on the final held byte
    } t_dp_stat;

    // Pipe-enter status text
    function automatic logic [7:0] enter_at(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2B; // '+'
            4'd1:    c = 8'h50; // 'P'
            4'd2:    c = 8'h49; // 'I'
            4'd3:    c = 8'h50; // 'P'
            4'd4:    c = 8'h45; // 'E'
            4'd5:    c = 8'h20; // ' '
            4'd6:    c = 8'h37; // '7'
            4'd7:    c = 8'h38; // '8'
            4'd8:    c = 8'h37; // '7'
            4'd9:    c = 8'h38; // '8'
            4'd10:   c = 8'h42; // 'B'
            4'd11:   c = 8'h38; // '8'
            4'd12:   c = 8'h41; // 'A'
            4'd13:   c = 8'h45; // 'E'
            4'd14:   c = 8'h0D; // CR
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Pipe-exit status text
    function automatic logic [7:0] exit_at(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2B; // '+'
            4'd1:    c = 8'h45; // 'E'
            4'd2:    c = 8'h53; // 'S'
            4'd3:    c = 8'h54; // 'T'
            4'd4:    c = 8'h54; // 'T'
            4'd5:    c = 8'h43; // 'C'
            4'd6:    c = 8'h20; // ' '
            4'd7:    c = 8'h43; // 'C'
            4'd8:    c = 8'h46; // 'F'
            4'd9:    c = 8'h42; // 'B'
            4'd10:   c = 8'h35; // '5'
            4'd11:   c = 8'h32; // '2'
            4'd12:   c = 8'h44; // 'D'
            4'd13:   c = 8'h33; // '3'
            4'd14:   c = 8'h35; // '5'
            default: c = 8'h0D; // CR
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/rfa_if.sv
// Valid/ready channel interfaces of the radio frame assembler.
// No dependencies.
interface rfa_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfa_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

FILE: hdl/radio_frame_assembler.sv
// Radio frame assembler, top level: joins controller and datapath.
// Depends on rfa_pkg, rfa_if, rfa_ctrl and rfa_dp.
//
// Usage:
//   i_rx carries received radio bytes, one word per valid/ready handshake.
//   o_frame returns committed frame bytes in arrival order; frame_last marks
//   the final byte of each frame. i_cfg_we/i_cfg_wdata set frame_length;
//   write it only while no word is in flight.
//   The first 17 bytes of a frame are held in a small memory. If the frame
//   so far equals the pipe-enter or pipe-exit status text, it is dropped.
//   Once past the texts (or when the frame completes), the held bytes leave
//   as a burst of up to 17 words once the controller is in its burst state,
//   one per cycle while the receiver is ready; input is blocked meanwhile.
//   Later bytes pass straight through: result in the cycle after acceptance,
//   and a new word may be accepted every cycle while the receiver is ready.
//   The burst reads the held bytes one at a time through the single read
//   port of the held-byte memory.
//   Reset (synchronous, active low) sets frame_length to 256, clears the
//   fill count and empties the output register.
//   A stalled receiver holds the output word; the input then waits too.
module radio_frame_assembler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    rfa_rx_if.sink       i_rx,
    rfa_frame_if.source  o_frame
);

    rfa_pkg::t_ctl_cmd cmd;
    rfa_pkg::t_dp_stat stat;
    logic              in_ready;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              out_last;

    // Controller
    rfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    rfa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_byte    (i_rx.rx_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (o_frame.ready),
        .o_out_valid  (out_valid),
        .o_frame_byte (out_byte),
        .o_frame_last (out_last)
    );

    assign i_rx.ready         = in_ready;
    assign o_frame.valid      = out_valid;
    assign o_frame.frame_byte = out_byte;
    assign o_frame.frame_last = out_last;

endmodule

FILE: hdl/rfa_ctrl.sv
// Controller of the radio frame assembler: input handshake and burst sequencing.
// Depends on rfa_pkg.
module rfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rfa_pkg::t_dp_stat i_stat,
    output rfa_pkg::t_ctl_cmd o_cmd
);

    rfa_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.take_word = 1'b0;
        o_cmd.emit_held = 1'b0;
        unique case (r_state)
            rfa_pkg::ST_IDLE: begin
                o_in_ready      = i_stat.slot_free;
                o_cmd.take_word = i_in_valid && i_stat.slot_free;
                if (o_cmd.take_word && i_stat.want_burst) begin
                    n_state = rfa_pkg::ST_BURST;
                end
            end
            rfa_pkg::ST_BURST: begin
                o_cmd.emit_held = i_stat.slot_free;
                if (i_stat.slot_free && i_stat.burst_end) begin
                    n_state = rfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/rfa_dp.sv
// Datapath of the radio frame assembler: fill count, text match flags,
// held-byte memory, burst index and output register. Depends on rfa_pkg.
`include "assert_macros.svh"
module rfa_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic [7:0]        i_rx_byte,
    input  rfa_pkg::t_ctl_cmd i_cmd,
    output rfa_pkg::t_dp_stat o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_frame_byte,
    output logic              o_frame_last
);

    logic [15:0]        r_len;
    logic [15:0]        r_fill;
    logic               r_enter_ok;
    logic               r_exit_ok;
    rfa_pkg::t_hold_idx r_idx;
    rfa_pkg::t_hold_idx r_end;
    logic               r_flag;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic [7:0]         r_held [rfa_pkg::HOLD_LEN];

    logic [16:0] n_count;
    logic        frame_done;
    logic        in_hold;
    logic        enter_hit;
    logic        exit_hit;
    logic        text_hit;
    logic        want_single;
    logic        slot_free;

    // Decision for the word at the input
    always_comb begin
        n_count     = {1'b0, r_fill} + 17'd1;
        frame_done  = n_count >= {1'b0, r_len};
        in_hold     = r_fill < 16'(rfa_pkg::HOLD_LEN);
        enter_hit   = (r_fill == 16'(rfa_pkg::ENTER_TEXT_LEN - 1)) && r_enter_ok
                      && (i_rx_byte == rfa_pkg::enter_at(4'(rfa_pkg::ENTER_TEXT_LEN - 1)));
        exit_hit    = (r_fill == 16'(rfa_pkg::EXIT_TEXT_LEN - 1)) && r_exit_ok
                      && (i_rx_byte == rfa_pkg::exit_at(4'(rfa_pkg::EXIT_TEXT_LEN - 1)));
        text_hit    = enter_hit || exit_hit;
        slot_free   = !r_out_valid || i_out_ready;
        want_single = frame_done ? !in_hold
                                 : (!text_hit && (n_count > 17'(rfa_pkg::HOLD_LEN)));
        o_stat.slot_free  = slot_free;
        o_stat.want_burst = frame_done ? in_hold
                                       : (!text_hit && (n_count == 17'(rfa_pkg::HOLD_LEN)));
        o_stat.burst_end  = r_idx == r_end;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= rfa_pkg::FRAME_LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    // Fill count and running text match flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_enter_ok <= 1'b1;
            r_exit_ok  <= 1'b1;
        end else if (i_cmd.take_word) begin
            if (frame_done || text_hit) begin
                r_fill     <= '0;
                r_enter_ok <= 1'b1;
                r_exit_ok  <= 1'b1;
            end else begin
                r_fill     <= n_count[15:0];
                r_enter_ok <= r_enter_ok && (r_fill < 16'(rfa_pkg::ENTER_TEXT_LEN))
                              && (i_rx_byte == rfa_pkg::enter_at(r_fill[3:0]));
                r_exit_ok  <= r_exit_ok && (r_fill < 16'(rfa_pkg::EXIT_TEXT_LEN))
                              && (i_rx_byte == rfa_pkg::exit_at(r_fill[3:0]));
            end
        end
    end

    // Held-byte memory, written while the frame prefix is filling
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_word && in_hold) begin
            r_held[r_fill[4:0]] <= i_rx_byte;
        end
    end

    // Burst index and end marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_end  <= '0;
            r_flag <= 1'b0;
        end else if (i_cmd.take_word) begin
            r_idx  <= '0;
            r_end  <= r_fill[4:0];
            r_flag <= frame_done;
        end else if (i_cmd.emit_held) begin
            r_idx  <= r_idx + 5'd1;
        end
    end

    // Output register: pass-through word or registered memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.take_word && want_single) || i_cmd.emit_held) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_held) begin
            r_out_byte <= r_held[r_idx];
            r_out_last <= r_flag && (r_idx == r_end);
        end else if (i_cmd.take_word && want_single) begin
            r_out_byte <= i_rx_byte;
            r_out_last <= frame_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;

    // Checks
    `RFA_ASSERT(a_done_clears_fill, i_clk, i_rst_n, (i_cmd.take_word && frame_done) |=> (r_fill == 16'd0))
    `RFA_ASSERT(a_burst_in_range, i_clk, i_rst_n, i_cmd.emit_held |-> (r_idx <= r_end && r_end <= 5'd16))
    `RFA_NEVER(a_no_overwrite, i_clk, i_rst_n, (i_cmd.take_word || i_cmd.emit_held) && !slot_free)
    `RFA_NEVER(a_cmd_exclusive, i_clk, i_rst_n, i_cmd.take_word && i_cmd.emit_held)

endmodule

FILE: verif/radio_frame_assembler_tb.sv
// Self-checking testbench for radio_frame_assembler: directed table, then random frames.
// Depends on rfa_pkg, rfa_if and the radio_frame_assembler RTL.
`timescale 1ns / 100ps

module radio_frame_assembler_tb;

    localparam int RANDOM_WORDS  = 170;
    localparam int SETTLE_CYCLES = 24;   // covers a pass-through word plus a full held burst
    localparam int STALL_LIMIT   = 500;

    // Status texts as byte strings, first character in the top byte
    localparam logic [rfa_pkg::ENTER_TEXT_LEN*8-1:0] PIPE_ENTER = {"+PIPE 7878B8AE", 8'h0D};
    localparam logic [rfa_pkg::EXIT_TEXT_LEN*8-1:0]  PIPE_EXIT  = {"+ESTTC CFB52D35", 8'h0D};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row;

    // typed=1: the row carries its own expectation (has_word=0 means nothing comes out)
    typedef struct packed {
        t_row        kind;
        logic [15:0] value;
        logic        typed;
        logic        has_word;
        t_frame_word want;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    rfa_rx_if    rx_ch ();
    rfa_frame_if frame_ch ();

    radio_frame_assembler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_frame     (frame_ch)
    );

    // Frame assembly state mirrored from the block
    logic [15:0] len_cfg = rfa_pkg::FRAME_LEN_RESET;
    logic [15:0] fill = '0;
    logic [7:0]  prefix [rfa_pkg::HOLD_LEN];

    t_frame_word fresh_words [$];
    t_frame_word frame_due [$];
    logic [7:0]  pending [$];

    bit rx_up       = 1'b0;
    bit sender_calm = 1'b0;
    int err_count     = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int frames_seen   = 0;
    int texts_dropped = 0;
    int lengths_set   = 0;

    // Directed rows
    t_plan_row plan [$] = '{
        // after reset the length is 256: first word is held back
        '{ROW_WORD, 16'h00A5, 1'b1, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h003C, 1'b0, 1'b0, '{8'h00, 1'b0}},
        // length dropped to the fill: next word flushes the held bytes
        '{ROW_CFG,  16'd2,    1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h00C3, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_CFG,  16'd1,    1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0000, 1'b1, 1'b1, '{8'h00, 1'b1}},
        '{ROW_WORD, 16'h00FF, 1'b1, 1'b1, '{8'hFF, 1'b1}},
        // zero length: every word is a frame of its own
        '{ROW_CFG,  16'd0,    1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h005A, 1'b1, 1'b1, '{8'h5A, 1'b1}},
        // length equal to the enter text: frame completes before the text test
        '{ROW_CFG,  16'd15,   1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h002B, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0050, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0049, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0050, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0045, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0020, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0037, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0038, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0037, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0038, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0042, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0038, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0041, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0045, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h000D, 1'b0, 1'b0, '{8'h00, 1'b0}},
        // maximum length: first word of a long frame is held
        '{ROW_CFG,  16'hFFFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
        '{ROW_WORD, 16'h0080, 1'b1, 1'b0, '{8'h00, 1'b0}}
    };

    function automatic logic [7:0] enter_char(input int i);
        return PIPE_ENTER[(rfa_pkg::ENTER_TEXT_LEN - 1 - i) * 8 +: 8];
    endfunction

    function automatic logic [7:0] exit_char(input int i);
        return PIPE_EXIT[(rfa_pkg::EXIT_TEXT_LEN - 1 - i) * 8 +: 8];
    endfunction

    // Advance the frame state by one received word; results land in fresh_words
    function automatic void assemble_word(input logic [7:0] b);
        int unsigned n;
        int i;
        bit hit;
        fresh_words.delete();
        hit = 1'b0;
        if (fill < rfa_pkg::HOLD_LEN) begin
            prefix[fill] = b;
        end
        n = fill + 1;

        // length test wins over the text test
        if (n >= len_cfg) begin
            if (n <= rfa_pkg::HOLD_LEN) begin
                for (i = 0; i < n; i++) begin
                    fresh_words.push_back('{prefix[i], (i + 1 == n)});
                end
            end else begin
                fresh_words.push_back('{b, 1'b1});
            end
            fill = '0;
            return;
        end

        if (n == rfa_pkg::ENTER_TEXT_LEN) begin
            hit = 1'b1;
            for (i = 0; i < rfa_pkg::ENTER_TEXT_LEN; i++) begin
                if (prefix[i] != enter_char(i)) hit = 1'b0;
            end
        end
        if (n == rfa_pkg::EXIT_TEXT_LEN) begin
            hit = 1'b1;
            for (i = 0; i < rfa_pkg::EXIT_TEXT_LEN; i++) begin
                if (prefix[i] != exit_char(i)) hit = 1'b0;
            end
        end
        if (hit) begin
            fill = '0;
            texts_dropped++;
            return;
        end

        fill = n[15:0];
        if (n == rfa_pkg::HOLD_LEN) begin
            for (i = 0; i < rfa_pkg::HOLD_LEN; i++) begin
                fresh_words.push_back('{prefix[i], 1'b0});
            end
        end else if (n > rfa_pkg::HOLD_LEN) begin
            fresh_words.push_back('{b, 1'b0});
        end
    endfunction

    // Offer one word after a random gap, wait for acceptance, queue its results
    task automatic send_word(input logic [7:0] b, input bit typed, input bit typed_has,
                             input t_frame_word typed_word);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            if (rx_up) rx_ch.valid <= 1'b0;
            rx_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_up = 1'b1;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        words_sent++;
        assemble_word(b);
        if (typed) begin
            if (typed_has) frame_due.push_back(typed_word);
        end else begin
            foreach (fresh_words[k]) frame_due.push_back(fresh_words[k]);
        end
    endtask

    // Hold input until every expected word is out and the block has settled
    task automatic drain_results();
        if (rx_up) rx_ch.valid <= 1'b0;
        rx_up = 1'b0;
        while (frame_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [15:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_cfg = v;
        lengths_set++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stimulus: reset, directed rows, random phases, end of run
    initial begin : stimulus
        int r;
        int i;
        int pos;
        int budget;
        int text_len;
        int random_sent;
        bit use_exit;
        logic [15:0] new_len;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        random_sent   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_CFG) begin
                write_length(plan[r].value);
            end else begin
                send_word(plan[r].value[7:0], plan[r].typed, plan[r].has_word, plan[r].want);
            end
        end

        // Random phases: each picks a length, then sends texts and noise
        while (random_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0:       new_len = 16'd1;
                1:       new_len = $urandom_range(0, 1) ? 16'd0 : 16'd2;
                2:       new_len = 16'(rfa_pkg::ENTER_TEXT_LEN);
                3:       new_len = 16'(rfa_pkg::EXIT_TEXT_LEN);
                4:       new_len = 16'(rfa_pkg::HOLD_LEN);
                5:       new_len = 16'($urandom_range(18, 48));
                6:       new_len = rfa_pkg::FRAME_LEN_RESET;
                default: new_len = 16'hFFFF;
            endcase
            write_length(new_len);
            sender_calm = ($urandom_range(0, 2) == 0);
            budget = $urandom_range(15, 40);
            pending.delete();

            repeat (budget) begin
                if (pending.size() == 0) begin
                    // at a frame start, half the time a status text, sometimes damaged or cut short
                    if (fill == 0 && $urandom_range(0, 1)) begin
                        use_exit = $urandom_range(0, 1);
                        text_len = use_exit ? rfa_pkg::EXIT_TEXT_LEN : rfa_pkg::ENTER_TEXT_LEN;
                        for (i = 0; i < text_len; i++) begin
                            pending.push_back(use_exit ? exit_char(i) : enter_char(i));
                        end
                        case ($urandom_range(0, 5))
                            0: begin
                                pos = $urandom_range(0, text_len - 1);
                                pending[pos] = pending[pos] ^ 8'($urandom_range(1, 255));
                            end
                            1: begin
                                repeat ($urandom_range(1, text_len - 1)) void'(pending.pop_back());
                            end
                            default: ;
                        endcase
                    end else begin
                        repeat ($urandom_range(1, 20)) pending.push_back(8'($urandom_range(0, 255)));
                    end
                end
                send_word(pending.pop_front(), 1'b0, 1'b0, '0);
                random_sent++;
            end
        end

        drain_results();
        err_count += frame_due.size();
        $display("Covered %0d rx words over %0d length settings, %0d status texts dropped.",
                 words_sent, lengths_set, texts_dropped);
        $display("Checked %0d frame words closing %0d frames.", results_seen, frames_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: random stalls after each word, checks against the oldest expectation
    initial begin : receiver
        int stall;
        int stall_left;
        bit calm;
        t_frame_word got;
        t_frame_word want;

        frame_ch.ready = 1'b0;
        stall_left = 0;
        calm = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                stall_left = 0;
            end else if (frame_ch.valid && frame_ch.ready) begin
                got = '{frame_ch.frame_byte, frame_ch.frame_last};
                results_seen++;
                if (got.last) frames_seen++;
                if (frame_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected word, expected none, got %02h last=%0b",
                             $time, got.data, got.last);
                end else begin
                    want = frame_due.pop_front();
                    if (got.data !== want.data) begin
                        err_count++;
                        $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, got.data);
                    end
                    if (got.last !== want.last) begin
                        err_count++;
                        $display("%0t: frame_last mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
                // occasionally switch between stalling and a calm stretch
                if ($urandom_range(0, 39) == 0) calm = !calm;
                stall = calm ? 0 : $urandom_range(0, 17);
                if (stall > 0) begin
                    frame_ch.ready <= 1'b0;
                    stall_left = stall;
                end
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) frame_ch.ready <= 1'b1;
            end else if (!frame_ch.ready) begin
                frame_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (rx_ch.valid && rx_ch.ready)
                    || (frame_ch.valid && frame_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, quiet);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
